/* src/imubmc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imubmc_pkg
// Shared types and constants for the IMU bias and matrix calibration unit.
// ----------------------------------------------------------------------------
package imubmc_pkg;

  localparam int unsigned RawWidth    = 16;
  localparam int unsigned BiasWidth   = 20;
  localparam int unsigned FieldStride = 20;
  localparam int unsigned NumAxes     = 3;
  localparam int unsigned RegWidth    = 60;
  localparam int unsigned NumRegs     = 8;
  localparam int unsigned CfgIdxWidth = 4;
  // raw * 16 - bias stays within 21 signed bits
  localparam int unsigned DiffWidth   = 21;
  localparam int unsigned FracShift   = 16;
  localparam int unsigned OutWidth    = 32;

  // register indexes
  localparam logic [CfgIdxWidth-1:0] RegAccBias  = 4'd0;
  localparam logic [CfgIdxWidth-1:0] RegGyroBias = 4'd1;
  localparam logic [CfgIdxWidth-1:0] RegAccRow0  = 4'd2;
  localparam logic [CfgIdxWidth-1:0] RegAccRow1  = 4'd3;
  localparam logic [CfgIdxWidth-1:0] RegAccRow2  = 4'd4;
  localparam logic [CfgIdxWidth-1:0] RegGyroRow0 = 4'd5;
  localparam logic [CfgIdxWidth-1:0] RegGyroRow1 = 4'd6;
  localparam logic [CfgIdxWidth-1:0] RegGyroRow2 = 4'd7;

  typedef logic [NumAxes-1:0][RawWidth-1:0] raw_vec_t;
  typedef logic [NumAxes-1:0][RegWidth-1:0] matrix_t;

  typedef struct packed {
    logic signed [RawWidth-1:0] acc_x_raw;
    logic signed [RawWidth-1:0] acc_y_raw;
    logic signed [RawWidth-1:0] acc_z_raw;
    logic signed [RawWidth-1:0] gyro_x_raw;
    logic signed [RawWidth-1:0] gyro_y_raw;
    logic signed [RawWidth-1:0] gyro_z_raw;
  } in_t;

  typedef struct packed {
    logic signed [OutWidth-1:0] acc_x_cal;
    logic signed [OutWidth-1:0] acc_y_cal;
    logic signed [OutWidth-1:0] acc_z_cal;
    logic signed [OutWidth-1:0] gyro_x_cal;
    logic signed [OutWidth-1:0] gyro_y_cal;
    logic signed [OutWidth-1:0] gyro_z_cal;
  } out_t;

  typedef struct packed {
    logic [RegWidth-1:0] acc_bias;
    logic [RegWidth-1:0] gyro_bias;
    matrix_t             acc_rows;
    matrix_t             gyro_rows;
  } cfg_t;

endpackage
`default_nettype wire

/* src/imubmc_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imubmc_cfg
// Calibration register file: bias vectors and matrix rows, written by index.
// ----------------------------------------------------------------------------
module imubmc_cfg (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid_i,
  input  wire logic [imubmc_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  wire logic [imubmc_pkg::RegWidth-1:0]     cfg_data_i,
  output imubmc_pkg::cfg_t                         cfg_o
);

  imubmc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_i)
        imubmc_pkg::RegAccBias:  cfg_d.acc_bias     = cfg_data_i;
        imubmc_pkg::RegGyroBias: cfg_d.gyro_bias    = cfg_data_i;
        imubmc_pkg::RegAccRow0:  cfg_d.acc_rows[0]  = cfg_data_i;
        imubmc_pkg::RegAccRow1:  cfg_d.acc_rows[1]  = cfg_data_i;
        imubmc_pkg::RegAccRow2:  cfg_d.acc_rows[2]  = cfg_data_i;
        imubmc_pkg::RegGyroRow0: cfg_d.gyro_rows[0] = cfg_data_i;
        imubmc_pkg::RegGyroRow1: cfg_d.gyro_rows[1] = cfg_data_i;
        imubmc_pkg::RegGyroRow2: cfg_d.gyro_rows[2] = cfg_data_i;
        default: ; // unknown index, beat is dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

/* src/imubmc_sensor.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imubmc_sensor
// Three-stage datapath for one sensor: bias subtract, 3x3 products, row sums.
// ----------------------------------------------------------------------------
module imubmc_sensor #(
  parameter int unsigned COEF_WIDTH = 20,
  parameter int unsigned SUM_WIDTH  = 43
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    en_i,
  input  wire imubmc_pkg::raw_vec_t                    raw_i,
  input  wire logic [imubmc_pkg::RegWidth-1:0]         bias_i,
  input  wire imubmc_pkg::matrix_t                     rows_i,
  output logic [imubmc_pkg::NumAxes-1:0][SUM_WIDTH-1:0] sum_o
);

  localparam int unsigned NumAxes   = imubmc_pkg::NumAxes;
  localparam int unsigned DiffWidth = imubmc_pkg::DiffWidth;
  localparam int unsigned ProdWidth = DiffWidth + COEF_WIDTH;
  localparam logic [SUM_WIDTH-1:0] RoundHalf =
    SUM_WIDTH'(2 ** (imubmc_pkg::FracShift - 1));

  logic [NumAxes-1:0][DiffWidth-1:0]                diff_d, diff_q;
  logic [NumAxes-1:0][NumAxes-1:0][ProdWidth-1:0]   prod_d, prod_q;
  logic [NumAxes-1:0][SUM_WIDTH-1:0]                sum_d, sum_q;

  // stage 1: raw * 16 - bias
  always_comb begin
    for (int k = 0; k < NumAxes; k++) begin
      diff_d[k] = {raw_i[k][imubmc_pkg::RawWidth-1], raw_i[k], 4'h0}
                - {bias_i[imubmc_pkg::FieldStride*k + imubmc_pkg::BiasWidth - 1],
                   bias_i[imubmc_pkg::FieldStride*k +: imubmc_pkg::BiasWidth]};
    end
  end

  // stage 2: nine products, coefficient is the low bits of its field
  always_comb begin
    for (int i = 0; i < NumAxes; i++) begin
      for (int k = 0; k < NumAxes; k++) begin
        prod_d[i][k] = ProdWidth'($signed(diff_q[k]))
                     * ProdWidth'($signed(rows_i[i][imubmc_pkg::FieldStride*k +: COEF_WIDTH]));
      end
    end
  end

  // stage 3: row sums with the rounding half folded in
  always_comb begin
    for (int i = 0; i < NumAxes; i++) begin
      sum_d[i] = SUM_WIDTH'($signed(prod_q[i][0]))
               + SUM_WIDTH'($signed(prod_q[i][1]))
               + SUM_WIDTH'($signed(prod_q[i][2]))
               + RoundHalf;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      diff_q <= diff_d;
      prod_q <= prod_d;
      sum_q  <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule
`default_nettype wire

/* src/imubmc_round.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imubmc_round
// Drops the fraction bits of a pre-rounded sum and saturates to Q15.16.
// ----------------------------------------------------------------------------
module imubmc_round #(
  parameter int unsigned SUM_WIDTH = 43
) (
  input  wire logic [SUM_WIDTH-1:0]              sum_i,
  output logic [imubmc_pkg::OutWidth-1:0]        res_o
);

  localparam int unsigned OutWidth = imubmc_pkg::OutWidth;
  localparam int unsigned ShWidth  = SUM_WIDTH - imubmc_pkg::FracShift;

  logic [ShWidth-1:0] sh;

  // floor shift of the sum, the half was added upstream
  assign sh = sum_i[SUM_WIDTH-1:imubmc_pkg::FracShift];

  if (ShWidth > OutWidth) begin : g_sat
    logic [ShWidth-OutWidth:0] top_bits;
    assign top_bits = sh[ShWidth-1:OutWidth-1];
    always_comb begin
      if ((&top_bits) || !(|top_bits)) begin
        res_o = sh[OutWidth-1:0];
      end else if (sh[ShWidth-1]) begin
        res_o = {1'b1, {(OutWidth-1){1'b0}}};
      end else begin
        res_o = {1'b0, {(OutWidth-1){1'b1}}};
      end
    end
  end else begin : g_ext
    assign res_o = OutWidth'($signed(sh));
  end

endmodule
`default_nettype wire

/* src/imu_bias_matrix_calibration_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imu_bias_matrix_calibration_unit
// Bias subtraction and 3x3 scale/misalignment correction for accel and gyro.
// ----------------------------------------------------------------------------
//  channel | signals                                 | direction
//  --------+-----------------------------------------+----------
//  input   | in_valid_i, in_ready_o, in_data_i       | in
//  result  | out_valid_o, out_ready_i, out_data_o    | out
//  config  | cfg_valid_i, cfg_ready_o, cfg_idx_i,    | in
//          | cfg_data_i                              |
//
// one beat is taken per cycle while the output is not stalled; a beat passes
// subtract, multiply, sum and round/saturate into the output register.
// reset clears all calibration registers to zero and empties the pipeline.
// a stalled result holds every stage; no beat is lost or repeated.
// ----------------------------------------------------------------------------
module imu_bias_matrix_calibration_unit #(
  parameter int unsigned COEF_WIDTH = 20
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire imubmc_pkg::in_t                     in_data_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output imubmc_pkg::out_t                         out_data_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [imubmc_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  wire logic [imubmc_pkg::RegWidth-1:0]     cfg_data_i
);

  localparam int unsigned NumAxes  = imubmc_pkg::NumAxes;
  localparam int unsigned SumWidth = imubmc_pkg::DiffWidth + COEF_WIDTH + 2;
  localparam int unsigned OutWidth = imubmc_pkg::OutWidth;

  imubmc_pkg::cfg_t     cfg;
  imubmc_pkg::raw_vec_t acc_vec, gyr_vec;
  logic [NumAxes-1:0][SumWidth-1:0] acc_sum, gyro_sum;
  logic [NumAxes-1:0][OutWidth-1:0] acc_res, gyro_res;

  logic                 en;
  logic [2:0]           vld_q, vld_d;
  logic                 out_vld_q, out_vld_d;
  imubmc_pkg::out_t     out_q, out_d;

  assign cfg_ready_o = 1'b1;

  imubmc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // whole pipe advances unless the output register is full and stalled
  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  assign acc_vec = {in_data_i.acc_z_raw, in_data_i.acc_y_raw, in_data_i.acc_x_raw};
  assign gyr_vec = {in_data_i.gyro_z_raw, in_data_i.gyro_y_raw, in_data_i.gyro_x_raw};

  imubmc_sensor #(
    .COEF_WIDTH(COEF_WIDTH),
    .SUM_WIDTH (SumWidth)
  ) u_acc (
    .clk_i (clk_i),
    .en_i  (en),
    .raw_i (acc_vec),
    .bias_i(cfg.acc_bias),
    .rows_i(cfg.acc_rows),
    .sum_o (acc_sum)
  );

  imubmc_sensor #(
    .COEF_WIDTH(COEF_WIDTH),
    .SUM_WIDTH (SumWidth)
  ) u_gyro (
    .clk_i (clk_i),
    .en_i  (en),
    .raw_i (gyr_vec),
    .bias_i(cfg.gyro_bias),
    .rows_i(cfg.gyro_rows),
    .sum_o (gyro_sum)
  );

  for (genvar i = 0; i < NumAxes; i++) begin : g_round
    imubmc_round #(.SUM_WIDTH(SumWidth)) u_acc_rnd (
      .sum_i(acc_sum[i]),
      .res_o(acc_res[i])
    );
    imubmc_round #(.SUM_WIDTH(SumWidth)) u_gyro_rnd (
      .sum_i(gyro_sum[i]),
      .res_o(gyro_res[i])
    );
  end

  always_comb begin
    out_d            = out_q;
    vld_d            = vld_q;
    out_vld_d        = out_vld_q;
    if (en) begin
      vld_d            = {vld_q[1:0], in_valid_i};
      out_vld_d        = vld_q[2];
      out_d.acc_x_cal  = acc_res[0];
      out_d.acc_y_cal  = acc_res[1];
      out_d.acc_z_cal  = acc_res[2];
      out_d.gyro_x_cal = gyro_res[0];
      out_d.gyro_y_cal = gyro_res[1];
      out_d.gyro_z_cal = gyro_res[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      vld_q     <= vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // an accepted beat enters the first stage
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted beat missing from first stage");

  // a stalled pipe keeps its last stage
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en && vld_q[2] |=> vld_q[2] && out_vld_q)
    else $error("stalled beat lost");

  // last stage reaches the output register when the pipe moves
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && vld_q[2] |=> out_valid_o)
    else $error("beat dropped before output register");

  // an empty output register never blocks the input
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output register");
`endif

endmodule
`default_nettype wire
